// ===== src/bdcr_pkg.sv =====
// Shared types and constants for the button debounce and change report block.
// Used by the channel interfaces, the state core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bdcr_pkg;

    // Number of button lines and width of the per-button stable counter
    localparam int BUTTONS = 3;
    localparam int CNT_W   = 8;

    // Threshold after reset and the saturation value of a counter
    localparam logic [CNT_W-1:0] THR_RESET = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // Item kinds
    typedef enum logic [1:0] {
        MODE_POLL  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // One result item
    typedef struct packed {
        logic [BUTTONS-1:0] debounced_state;
        logic [BUTTONS-1:0] reported_mask;
        logic               any_changed;
        logic               irq_pending;
    } result_t;

endpackage : bdcr_pkg

`default_nettype wire

// ===== src/bdcr_in_if.sv =====
// Input channel: valid/ready handshake carrying one item (mode and raw buttons).
// Depends on bdcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdcr_in_if
    import bdcr_pkg::*;
();
    logic               valid;
    logic               ready;
    mode_t              mode;
    logic [BUTTONS-1:0] raw_buttons;

    modport source (output valid, output mode, output raw_buttons, input ready);
    modport sink   (input valid, input mode, input raw_buttons, output ready);
endinterface : bdcr_in_if

`default_nettype wire

// ===== src/bdcr_out_if.sv =====
// Output channel: valid/ready handshake carrying one result item.
// Depends on bdcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdcr_out_if
    import bdcr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BUTTONS-1:0] debounced_state;
    logic [BUTTONS-1:0] reported_mask;
    logic               any_changed;
    logic               irq_pending;

    modport source (output valid, output debounced_state, output reported_mask,
                    output any_changed, output irq_pending, input ready);
    modport sink   (input valid, input debounced_state, input reported_mask,
                    input any_changed, input irq_pending, output ready);
endinterface : bdcr_out_if

`default_nettype wire

// ===== src/bdcr_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying the threshold.
// Depends on bdcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdcr_cfg_if
    import bdcr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] debounce_threshold;

    modport source (output valid, output debounce_threshold, input ready);
    modport sink   (input valid, input debounce_threshold, output ready);
endinterface : bdcr_cfg_if

`default_nettype wire

// ===== src/button_debounce_change_report.sv =====
// Button debounce with change report: input register, state core, result register.
// An accepted item passes from the input register through the state core into the result register, which offers it.
// Throughput: one item per cycle; the input and result registers form a pipeline
// that keeps accepting while a result waits, as long as the result stage drains.
// Reset (rst_n, asynchronous, active low): all state zero, threshold 4, both stages empty.
// Depends on bdcr_pkg, bdcr_in_if, bdcr_out_if, bdcr_cfg_if and bdcr_core.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_change_report
    import bdcr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bdcr_in_if.sink     in_ch,
    bdcr_out_if.source  out_ch,
    bdcr_cfg_if.sink    cfg_ch
);

    logic               in_valid_reg;
    mode_t              mode_reg;
    logic [BUTTONS-1:0] raw_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            res;
    logic               advance;

    // Item moves from the input register into the result register
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign cfg_ch.ready = 1'b1;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            mode_reg <= in_ch.mode;
            raw_reg  <= in_ch.raw_buttons;
        end
    end

    // State update
    bdcr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .mode     (mode_reg),
        .raw      (raw_reg),
        .cfg_we   (cfg_ch.valid && cfg_ch.ready),
        .cfg_data (cfg_ch.debounce_threshold),
        .res      (res)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.debounced_state = out_reg.debounced_state;
    assign out_ch.reported_mask   = out_reg.reported_mask;
    assign out_ch.any_changed     = out_reg.any_changed;
    assign out_ch.irq_pending     = out_reg.irq_pending;

    // Only a read reports a mask
    a_mask_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (mode_reg != MODE_READ) |=> out_ch.reported_mask == '0)
        else $error("reported mask set by an item that is not a read");

    // Clear leaves nothing debounced and nothing pending
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (mode_reg == MODE_CLEAR)
        |=> (out_ch.debounced_state == '0) && !out_ch.irq_pending)
        else $error("clear left state behind");

    // A flip always raises the pending flag
    a_flip_pends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.any_changed |-> res.irq_pending)
        else $error("debounced bit flipped without pending flag");

    // A transfer into a full input stage must be drained in the same cycle
    a_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_valid_reg |-> advance)
        else $error("input stage overwritten");

endmodule : button_debounce_change_report

`default_nettype wire

// ===== src/bdcr_core.sv =====
// Debounce state core: candidate word, per-button counters, debounced and
// last-read bits, change mask and pending flag. Depends on bdcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdcr_core
    import bdcr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire mode_t              mode,
    input  wire logic [BUTTONS-1:0] raw,
    input  wire logic               cfg_we,
    input  wire logic [CNT_W-1:0]   cfg_data,
    output result_t                 res
);

    logic [CNT_W-1:0]   thr_reg;
    logic [BUTTONS-1:0] deb_reg,  deb_next;
    logic [BUTTONS-1:0] last_reg, last_next;
    logic [BUTTONS-1:0] pend_reg, pend_next;
    logic               flag_reg, flag_next;
    logic [BUTTONS-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0]   cnt_reg  [BUTTONS];
    logic [CNT_W-1:0]   cnt_next [BUTTONS];
    logic [CNT_W-1:0]   cnt_inc  [BUTTONS];
    logic [BUTTONS-1:0] reported;
    logic               changed;

    // Saturating increment per button
    always_comb
    begin
        for (int i = 0; i < BUTTONS; i++)
        begin
            cnt_inc[i] = (cnt_reg[i] == CNT_MAX) ? cnt_reg[i] : cnt_reg[i] + CNT_W'(1);
        end
    end

    // Next state for one item
    always_comb
    begin
        deb_next  = deb_reg;
        last_next = last_reg;
        pend_next = pend_reg;
        flag_next = flag_reg;
        cand_next = cand_reg;
        cnt_next  = cnt_reg;
        reported  = '0;
        changed   = 1'b0;
        case (mode)
            MODE_POLL:
            begin
                if (raw != cand_reg)
                begin
                    // new candidate word restarts every count
                    cand_next = raw;
                    for (int i = 0; i < BUTTONS; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                end
                else
                begin
                    for (int i = 0; i < BUTTONS; i++)
                    begin
                        if (raw[i] != deb_reg[i])
                        begin
                            if (cnt_inc[i] >= thr_reg)
                            begin
                                deb_next[i]  = ~deb_reg[i];
                                pend_next[i] = 1'b1;
                                flag_next    = 1'b1;
                                cnt_next[i]  = '0;
                                changed      = 1'b1;
                            end
                            else
                            begin
                                cnt_next[i] = cnt_inc[i];
                            end
                        end
                        else
                        begin
                            cnt_next[i] = '0;
                        end
                    end
                end
            end
            MODE_READ:
            begin
                // hand out the mask, then re-arm on any unread difference
                reported  = pend_reg;
                pend_next = deb_reg ^ last_reg;
                flag_next = (deb_reg != last_reg);
                last_next = deb_reg;
            end
            MODE_CLEAR:
            begin
                deb_next  = '0;
                last_next = '0;
                pend_next = '0;
                flag_next = 1'b0;
                cand_next = '0;
                for (int i = 0; i < BUTTONS; i++)
                begin
                    cnt_next[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result of the item as it leaves the core
    always_comb
    begin
        res.debounced_state = deb_next;
        res.reported_mask   = reported;
        res.any_changed     = changed;
        res.irq_pending     = flag_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            deb_reg  <= '0;
            last_reg <= '0;
            pend_reg <= '0;
            flag_reg <= 1'b0;
            cand_reg <= '0;
            for (int i = 0; i < BUTTONS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (step)
            begin
                deb_reg  <= deb_next;
                last_reg <= last_next;
                pend_reg <= pend_next;
                flag_reg <= flag_next;
                cand_reg <= cand_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule : bdcr_core

`default_nettype wire
